// ----- rtl/sac_pkg.sv -----
// shared types, constants and coefficient tables for the stereo compressor
// no dependencies
`default_nettype none
package sac_pkg;

  localparam int COEF_W = 25;
  localparam int TAB_N  = 11;

  typedef logic signed [COEF_W-1:0] coef_t;

  typedef enum logic [2:0] {
    REG_SENSE  = 3'd0,
    REG_ATTACK = 3'd1,
    REG_TONE   = 3'd2,
    REG_VOLUME = 3'd3,
    REG_BYPASS = 3'd4
  } reg_index_t;

  typedef enum logic [2:0] {
    TAB_SENS, TAB_MAKEUP, TAB_B0, TAB_A1, TAB_TG
  } tab_sel_t;

  typedef enum logic [2:0] {
    C_IDLE, C_MUL, C_ADD, C_BG, C_BGR, C_DONE
  } coef_state_t;

  typedef enum logic [4:0] {
    L_IDLE, L_DET, L_DETR, L_ENVM, L_ENVA, L_DIV, L_SQRT, L_SMM, L_SMA,
    L_Y1, L_Y2, L_BG, L_A1, L_W, L_VOL, L_OUT, L_HOLD
  } lane_state_t;

  typedef struct packed {
    logic start;
    logic ack;
  } lane_ctl_t;

  typedef struct packed {
    coef_t sens;
    coef_t makeup;
    coef_t bg;
    coef_t a1;
  } coef_set_t;

  localparam logic [16:0] ATTACK_SLOW  = 17'd2244;
  localparam logic [16:0] RELEASE_SLOW = 17'd71049;
  localparam logic [16:0] ATTACK_FAST  = 17'd4483;
  localparam logic [16:0] RELEASE_FAST = 17'd35564;
  localparam logic [12:0] SMOOTH_COEF  = 13'd5243;
  localparam logic [23:0] ONE_Q23      = 24'h800000;
  localparam logic [31:0] ENV_ONE      = 32'h1000_0000;

  localparam coef_t SENS_TAB [TAB_N] = '{
    25'sd208896, 25'sd331264, 25'sd525312, 25'sd832512, 25'sd1048576, 25'sd1319936,
    25'sd1661440, 25'sd2092032, 25'sd3315712, 25'sd5255168, 25'sd8328704};
  localparam coef_t MAKEUP_TAB [TAB_N] = '{
    25'sd1480704, 25'sd1661440, 25'sd1864192, 25'sd2092032, 25'sd2347008,
    25'sd2633728, 25'sd3315712, 25'sd4174336, 25'sd5896192, 25'sd8328704,
    25'sd11764736};
  localparam coef_t B0_TAB [TAB_N] = '{
    25'sd543571, 25'sd620933, 25'sd708791, 25'sd808416, 25'sd921186, 25'sd1048576,
    25'sd1193579, 25'sd1360065, 25'sd1551216, 25'sd1770687, 25'sd2022674};
  localparam coef_t A1_TAB [TAB_N] = '{
    -25'sd471247, -25'sd538304, -25'sd614456, -25'sd700799, -25'sd798520,
    -25'sd908893, -25'sd1053896, -25'sd1220382, -25'sd1411533, -25'sd1631004,
    -25'sd1882992};
  localparam coef_t TG_TAB [TAB_N] = '{
    25'sd976252, 25'sd965948, 25'sd954241, 25'sd940957, 25'sd925910, 25'sd908893,
    25'sd908893, 25'sd908893, 25'sd908893, 25'sd908893, 25'sd908893};

  function automatic coef_t tab_value(tab_sel_t sel, logic [3:0] idx);
    logic [3:0] k;
    coef_t      v;
    k = (idx > 4'(TAB_N - 1)) ? 4'(TAB_N - 1) : idx;
    case (sel)
      TAB_SENS:   v = SENS_TAB[k];
      TAB_MAKEUP: v = MAKEUP_TAB[k];
      TAB_B0:     v = B0_TAB[k];
      TAB_A1:     v = A1_TAB[k];
      TAB_TG:     v = TG_TAB[k];
      default:    v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/stereo_audio_compressor_unit.sv -----
// top level of the stereo feed-forward compressor
// depends on sac_pkg, sac_coef, sac_lane, sac_merge
`default_nettype none
// One stereo item in, one stereo item out. Items are taken one at a time: after
// an item is accepted in_stall stays high until its result is loaded into the
// output register, which can still be waiting on out_stall when the next item
// comes in. With bypass_on set the raw pair is loaded straight from the input
// registers, skipping the coefficient and lane logic. Otherwise the coefficient
// interpolator runs first (one shared multiplier stepping through five knob
// tables and the tone gain product), then both channel lanes run side by side on
// one multiplier each. When the envelope is above one, a radix-4 divider and a
// two-step-per-cycle square root form the 1/sqrt gain before the lane goes on,
// and each lane waits in its hold state until the result is loaded. The next item
// can be accepted in the cycle after the result is loaded. Configuration is a
// plain write port whose registers the lanes read live, so write it only while
// no item is in flight.
module stereo_audio_compressor_unit
  import sac_pkg::*;
#(
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic [2:0]                    cfg_index,
  input  wire logic [15:0]                   cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [SAMPLE_BITS-1:0] left_sample,
  input  wire logic signed [SAMPLE_BITS-1:0] right_sample,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0]      left_result,
  output logic signed [SAMPLE_BITS-1:0]      right_result
);

  // configuration registers
  logic [15:0] sense_setting, tone_setting, volume_setting;
  logic        attack_fast, bypass_on;

  // item in flight
  logic busy, byp;
  logic signed [SAMPLE_BITS-1:0] xl, xr;

  logic      accept, coef_done, load;
  logic      done_l, done_r;
  coef_set_t coefs;
  lane_ctl_t lane_ctl;
  logic signed [SAMPLE_BITS-1:0] res_l, res_r;

  assign in_stall = busy;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      sense_setting  <= 16'd32768;
      attack_fast    <= 1'b0;
      tone_setting   <= 16'd32768;
      volume_setting <= 16'd32768;
      bypass_on      <= 1'b0;
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_SENSE:  sense_setting  <= cfg_data;
        REG_ATTACK: attack_fast    <= cfg_data[0];
        REG_TONE:   tone_setting   <= cfg_data;
        REG_VOLUME: volume_setting <= cfg_data;
        REG_BYPASS: bypass_on      <= cfg_data[0];
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  // busy from accept until the result lands in the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept) begin
      busy <= 1'b1;
    end else if (load) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byp <= bypass_on;
      xl  <= left_sample;
      xr  <= right_sample;
    end
  end

  // coefficients are refreshed per processed item
  sac_coef u_coef (
    .clk   (clk),
    .rst   (rst),
    .start (accept && !bypass_on),
    .sense (sense_setting),
    .tone  (tone_setting),
    .coefs (coefs),
    .done  (coef_done)
  );

  assign lane_ctl.start = coef_done;
  assign lane_ctl.ack   = load && !byp;

  sac_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_left (
    .clk         (clk),
    .rst         (rst),
    .ctl         (lane_ctl),
    .x           (xl),
    .coefs       (coefs),
    .attack_fast (attack_fast),
    .volume      (volume_setting),
    .done        (done_l),
    .result      (res_l)
  );

  sac_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_right (
    .clk         (clk),
    .rst         (rst),
    .ctl         (lane_ctl),
    .x           (xr),
    .coefs       (coefs),
    .attack_fast (attack_fast),
    .volume      (volume_setting),
    .done        (done_r),
    .result      (res_r)
  );

  // lanes finish at different times, the merge waits for both
  sac_merge #(.SAMPLE_BITS(SAMPLE_BITS)) u_merge (
    .clk          (clk),
    .rst          (rst),
    .busy         (busy),
    .bypass       (byp),
    .done_left    (done_l),
    .done_right   (done_r),
    .lane_left    (res_l),
    .lane_right   (res_r),
    .raw_left     (xl),
    .raw_right    (xr),
    .out_stall    (out_stall),
    .load         (load),
    .out_valid    (out_valid),
    .left_result  (left_result),
    .right_result (right_result)
  );

endmodule
`default_nettype wire

// ----- rtl/sac_coef.sv -----
// knob interpolation of sensitivity, makeup and tone coefficients
// depends on sac_pkg
`default_nettype none
module sac_coef
  import sac_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [15:0] sense,
  input  wire logic [15:0] tone,
  output coef_set_t        coefs,
  output logic             done
);

  coef_state_t state, state_next;
  tab_sel_t    sel;
  coef_t       sens, makeup, b0, a1, tg, bg;
  logic signed [50:0] prod;
  logic signed [25:0] op_a;
  logic signed [24:0] op_b;
  logic [15:0] knob;
  logic [19:0] p;
  coef_t       t0, t1;

  // p = knob * 10, segment index and fraction
  assign knob = (sel == TAB_SENS || sel == TAB_MAKEUP) ? sense : tone;
  assign p    = ({4'b0, knob} << 3) + ({4'b0, knob} << 1);
  assign t0   = tab_value(sel, p[19:16]);
  assign t1   = tab_value(sel, p[19:16] + 4'd1);

  always_comb begin
    state_next = state;
    unique case (state)
      C_IDLE:  if (start) state_next = C_MUL;
      C_MUL:   state_next = C_ADD;
      C_ADD:   state_next = (sel == TAB_TG) ? C_BG : C_MUL;
      C_BG:    state_next = C_BGR;
      C_BGR:   state_next = C_DONE;
      C_DONE:  state_next = C_IDLE;
      default: state_next = C_IDLE;
    endcase
  end

  always_comb begin
    op_a = '0;
    op_b = '0;
    done = 1'b0;
    unique case (state)
      C_MUL: begin
        op_a = 26'(t1) - 26'(t0);
        op_b = {9'b0, p[15:0]};
      end
      C_BG: begin
        op_a = 26'(b0);
        op_b = tg;
      end
      C_DONE: done = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
    if (state == C_IDLE) begin
      sel <= TAB_SENS;
    end
    if (state == C_ADD) begin
      unique case (sel)
        TAB_SENS:   sens   <= t0 + prod[40:16];
        TAB_MAKEUP: makeup <= t0 + prod[40:16];
        TAB_B0:     b0     <= t0 + prod[40:16];
        TAB_A1:     a1     <= t0 + prod[40:16];
        TAB_TG:     tg     <= t0 + prod[40:16];
        default: ;
      endcase
      if (sel != TAB_TG) begin
        sel <= tab_sel_t'(sel + 3'd1);
      end
    end
    if (state == C_BGR) begin
      bg <= prod[44:20];
    end
  end

  assign coefs = '{sens: sens, makeup: makeup, bg: bg, a1: a1};

endmodule
`default_nettype wire

// ----- rtl/sac_lane.sv -----
// one channel of the compressor: envelope, 1/sqrt gain, smoothing, tone, volume
// depends on sac_pkg; one shared multiplier, iterative divider and square root
`default_nettype none
module sac_lane
  import sac_pkg::*;
#(
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire lane_ctl_t                     ctl,
  input  wire logic signed [SAMPLE_BITS-1:0] x,
  input  wire coef_set_t                     coefs,
  input  wire logic                          attack_fast,
  input  wire logic [15:0]                   volume,
  output logic                               done,
  output logic signed [SAMPLE_BITS-1:0]      result
);

  localparam int SB = SAMPLE_BITS;
  localparam int DS = SB - 9;
  localparam int AW = (SB + 12 > 34) ? SB + 12 : 34;
  localparam int PW = AW + 25;

  lane_state_t state, state_next;

  logic [31:0] env, det, e_new;
  logic [23:0] sg, gr, s_new;
  logic signed [31:0] prev, w;
  logic signed [PW-1:0] prod, acc;
  logic signed [AW-1:0] op_a;
  logic signed [24:0]   op_b;
  logic [4:0]  cnt;
  logic [19:0] rem, dv, r1b, r2b;
  logic [20:0] r1, r2;
  logic        q1, q2;
  logic [46:0] quo, quo_next;
  logic [47:0] sv, sr, sbit, t_1, v_1, rr_1, b_1, t_2, v_2, rr_2;
  logic        ge1, ge2;
  logic [SB-1:0] ax;
  logic signed [34:0] esum;
  logic signed [25:0] ssum;
  logic signed [PW:0] wdiff;
  logic signed [PW-20:0] wsh;
  logic signed [PW-17:0] osh;
  logic signed [SB-1:0]  o_sat;
  logic [16:0] c;

  assign ax = x[SB-1] ? SB'(-x) : SB'(x);
  assign c  = (det > env) ? (attack_fast ? ATTACK_FAST : ATTACK_SLOW)
                          : (attack_fast ? RELEASE_FAST : RELEASE_SLOW);

  // envelope update with clamp to unsigned 32 bits
  always_comb begin
    esum = $signed({3'b0, env}) + $signed(prod[54:20]);
    if (esum[34]) e_new = '0;
    else if (esum[33:32] != 2'b0) e_new = 32'hFFFF_FFFF;
    else e_new = esum[31:0];
  end

  // smoothed gain with clamp to 0 .. one
  always_comb begin
    ssum = $signed({2'b0, sg}) + $signed(prod[45:20]);
    if (ssum[25]) s_new = '0;
    else if (ssum[24:0] > {1'b0, ONE_Q23}) s_new = ONE_Q23;
    else s_new = ssum[23:0];
  end

  // two restoring division steps per cycle on 2^62 / dv
  always_comb begin
    r1  = {rem, 1'b0};
    q1  = r1 >= {1'b0, dv};
    r1b = q1 ? 20'(r1 - {1'b0, dv}) : r1[19:0];
    r2  = {r1b, cnt == 5'd31};
    q2  = r2 >= {1'b0, dv};
    r2b = q2 ? 20'(r2 - {1'b0, dv}) : r2[19:0];
    quo_next = {quo[44:0], q1, q2};
  end

  // two digit-by-digit square root steps per cycle
  always_comb begin
    t_1  = sr + sbit;
    ge1  = sv >= t_1;
    v_1  = ge1 ? sv - t_1 : sv;
    rr_1 = ge1 ? (sr >> 1) + sbit : sr >> 1;
    b_1  = sbit >> 2;
    t_2  = rr_1 + b_1;
    ge2  = v_1 >= t_2;
    v_2  = ge2 ? v_1 - t_2 : v_1;
    rr_2 = ge2 ? (rr_1 >> 1) + b_1 : rr_1 >> 1;
  end

  // tone filter output, saturated to 32 bits
  always_comb begin
    wdiff = (PW+1)'(acc) - (PW+1)'(prod);
    wsh   = wdiff[PW:20];
    if (wsh[PW-20:31] != {(PW-50){wsh[PW-20]}})
      w = wsh[PW-20] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    else
      w = wsh[31:0];
  end

  // volume result, saturated to the sample width
  always_comb begin
    osh = prod[PW-1:16];
    if (osh[PW-17:SB-1] != {(PW-SB-15){osh[PW-17]}})
      o_sat = osh[PW-17] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
    else
      o_sat = osh[SB-1:0];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      L_IDLE:  if (ctl.start) state_next = L_DET;
      L_DET:   state_next = L_DETR;
      L_DETR:  state_next = L_ENVM;
      L_ENVM:  state_next = L_ENVA;
      L_ENVA:  state_next = (e_new > ENV_ONE) ? L_DIV : L_SMM;
      L_DIV:   if (cnt == 5'd0) state_next = L_SQRT;
      L_SQRT:  if (cnt == 5'd0) state_next = L_SMM;
      L_SMM:   state_next = L_SMA;
      L_SMA:   state_next = L_Y1;
      L_Y1:    state_next = L_Y2;
      L_Y2:    state_next = L_BG;
      L_BG:    state_next = L_A1;
      L_A1:    state_next = L_W;
      L_W:     state_next = L_VOL;
      L_VOL:   state_next = L_OUT;
      L_OUT:   state_next = L_HOLD;
      L_HOLD:  if (ctl.ack) state_next = L_IDLE;
      default: state_next = L_IDLE;
    endcase
  end

  always_comb begin
    op_a = '0;
    op_b = '0;
    done = 1'b0;
    unique case (state)
      L_DET: begin
        op_a = AW'({1'b0, ax});
        op_b = coefs.sens;
      end
      L_ENVM: begin
        op_a = AW'($signed({2'b0, det}) - $signed({2'b0, env}));
        op_b = {8'b0, c};
      end
      L_SMM: begin
        op_a = AW'($signed({1'b0, gr}) - $signed({1'b0, sg}));
        op_b = {12'b0, SMOOTH_COEF};
      end
      L_Y1: begin
        op_a = AW'(x);
        op_b = {1'b0, sg};
      end
      L_Y2: begin
        op_a = prod[23 +: AW];
        op_b = coefs.makeup;
      end
      L_BG: begin
        op_a = prod[20 +: AW];
        op_b = coefs.bg;
      end
      L_A1: begin
        op_a = AW'(prev);
        op_b = coefs.a1;
      end
      L_VOL: begin
        op_a = AW'(prev);
        op_b = {9'b0, volume};
      end
      L_HOLD: done = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      env   <= '0;
      sg    <= ONE_Q23;
      prev  <= '0;
    end else begin
      state <= state_next;
      if (state == L_ENVA) env  <= e_new;
      if (state == L_SMA)  sg   <= s_new;
      if (state == L_W)    prev <= w;
    end
  end

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
    unique case (state)
      L_DETR: begin
        if (prod[PW-1:DS+32] != '0) det <= 32'hFFFF_FFFF;
        else det <= prod[DS +: 32];
      end
      L_ENVA: begin
        gr  <= ONE_Q23;
        dv  <= e_new[31:12];
        rem <= '0;
        quo <= '0;
        cnt <= 5'd31;
      end
      L_DIV: begin
        rem <= r2b;
        quo <= quo_next;
        cnt <= cnt - 5'd1;
        if (cnt == 5'd0) begin
          sv   <= {1'b0, quo_next};
          sr   <= '0;
          sbit <= 48'h4000_0000_0000;
          cnt  <= 5'd11;
        end
      end
      L_SQRT: begin
        sv   <= v_2;
        sr   <= rr_2;
        sbit <= b_1 >> 2;
        cnt  <= cnt - 5'd1;
        if (cnt == 5'd0) gr <= rr_2[23:0];
      end
      L_A1:  acc    <= prod;
      L_OUT: result <= o_sat;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/sac_merge.sv -----
// merge of the two lane results or the bypassed pair into the output register
// depends on sac_pkg
`default_nettype none
module sac_merge
  import sac_pkg::*;
#(
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          busy,
  input  wire logic                          bypass,
  input  wire logic                          done_left,
  input  wire logic                          done_right,
  input  wire logic signed [SAMPLE_BITS-1:0] lane_left,
  input  wire logic signed [SAMPLE_BITS-1:0] lane_right,
  input  wire logic signed [SAMPLE_BITS-1:0] raw_left,
  input  wire logic signed [SAMPLE_BITS-1:0] raw_right,
  input  wire logic                          out_stall,
  output logic                               load,
  output logic                               out_valid,
  output logic signed [SAMPLE_BITS-1:0]      left_result,
  output logic signed [SAMPLE_BITS-1:0]      right_result
);

  logic pending;

  assign pending = busy && (bypass || (done_left && done_right));
  assign load    = pending && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      left_result  <= bypass ? raw_left : lane_left;
      right_result <= bypass ? raw_right : lane_right;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/sac_checker.sv -----
// port-level checks for the stereo compressor and their bind to the top level
// depends on stereo_audio_compressor_unit
`default_nettype none
module sac_checker #(
  parameter int SAMPLE_BITS = 24
) (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   in_valid,
  input wire logic                   in_stall,
  input wire logic                   out_valid,
  input wire logic                   out_stall,
  input wire logic [SAMPLE_BITS-1:0] left_result,
  input wire logic [SAMPLE_BITS-1:0] right_result
);

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  // one item at a time: an accepted item blocks the input next cycle
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input open right after an accept");

  // a new result means the item left the block, so the input is open
  a_result_frees: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !in_stall)
    else $error("result shown while item still in flight");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(left_result) && $stable(right_result)))
    else $error("stalled result changed");

endmodule

bind stereo_audio_compressor_unit sac_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_sac_checker (.*);
`default_nettype wire
